// ===== hdl/extent_free_list_allocator_defines.svh =====
// Assertion helpers for the extent allocator checker.
`ifndef EXTENT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define EXTENT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define EFLA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/efla_pkg.sv =====
package efla_pkg;

  localparam int POS_W  = 40;
  localparam int LEN_W  = 32;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLAIM   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_EXTRA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
  } ext_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic extra;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_done;
    logic two_out;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hdl/extent_free_list_allocator.sv =====
// First-fit extent allocator with coalescing.
// Input channel (in_valid_i / in_stall_o): one word carries kind_i (allocate,
// release, claim), offset_i and length_i. A word is taken when valid is high
// and stall is low; the block takes one word at a time.
// Output channel (out_valid_o / out_stall_i): one result word per input word
// with alloc_offset_o, grew_o, store_end_o and status_o.
// Operation: the free table is rewritten into the other half of a two-half RAM
// with registered read. Every word reads each entry of the current table in
// turn (fetch, then evaluate), with an extra write step for each entry that
// needs a second write (split, insert, or a merged extent written ahead of the
// entry after it). The next word is taken once the result is in the output
// register. Zero-length release/claim and the unused kind skip the scan.
// The output register lets a result wait while the next word is processed;
// a stalled receiver holds the block in its last cycle only when a new result
// is ready.
// Reset: table empty, store end zero. A cfg_we_i write loads the table with
// one free extent covering the new store size (none for size zero) and sets
// the store end; write only while idle.
module extent_free_list_allocator #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [efla_pkg::POS_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [efla_pkg::KIND_W-1:0]  kind_i,
  input  logic [efla_pkg::POS_W-1:0]   offset_i,
  input  logic [efla_pkg::LEN_W-1:0]   length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [efla_pkg::POS_W-1:0]   alloc_offset_o,
  output logic                         grew_o,
  output logic [efla_pkg::POS_W-1:0]   store_end_o,
  output logic                         status_o
);
  import efla_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  efla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  efla_dp #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .offset_i      (offset_i),
    .length_i      (length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .alloc_offset_o(alloc_offset_o),
    .grew_o        (grew_o),
    .store_end_o   (store_end_o),
    .status_o      (status_o)
  );

endmodule

// ===== hdl/efla_ram.sv =====
module efla_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/efla_ctrl.sv =====
module efla_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output efla_pkg::ctrl_cmd_t   cmd_o,
  input  efla_pkg::ctrl_sts_t   sts_i
);
  import efla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sts_i.skip || sts_i.scan_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.two_out ? ST_EXTRA : ST_FETCH;
      end
      ST_EXTRA: begin
        cmd_o.extra = 1'b1;
        state_d     = ST_FETCH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/efla_dp.sv =====
module efla_dp #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  efla_pkg::ctrl_cmd_t          cmd_i,
  output efla_pkg::ctrl_sts_t          sts_o,
  input  logic                         cfg_we_i,
  input  logic [efla_pkg::POS_W-1:0]   cfg_wdata_i,
  input  logic [efla_pkg::KIND_W-1:0]  kind_i,
  input  logic [efla_pkg::POS_W-1:0]   offset_i,
  input  logic [efla_pkg::LEN_W-1:0]   length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [efla_pkg::POS_W-1:0]   alloc_offset_o,
  output logic                         grew_o,
  output logic [efla_pkg::POS_W-1:0]   store_end_o,
  output logic                         status_o
);
  import efla_pkg::*;

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  off_q, len_q, end_q, at_q;
  logic [CW-1:0]     idx_q, wptr_q, cnt_q;
  logic              sel_q, done_q, pend_q, grew_q, st_q;
  ext_t              car_q, xtr_q;

  logic              out_valid_q, out_grew_q, out_st_q;
  logic [POS_W-1:0]  out_at_q, out_end_q;

  ext_t              rdata;
  logic              ram_we;
  logic [AW:0]       ram_waddr;
  ext_t              ram_wdata;

  // per-entry evaluation
  logic [POS_W-1:0]  s, l, e, rend, nl;
  logic              ev_wr, ev_two, ev_done, ev_pend, ev_st, ev_at_set;
  ext_t              ev_w, ev_x, ev_car;
  logic              room_rel, room_clm, skip;
  logic [CW:0]       live;

  // tail at the end of the scan
  logic              tail_wr, tail_st;
  ext_t              tail_w;
  logic [POS_W-1:0]  fin_at, fin_end;
  logic              fin_grew;

  assign skip = ((kind_q != KIND_ALLOC) && (kind_q != KIND_RELEASE) &&
                 (kind_q != KIND_CLAIM)) ||
                ((kind_q != KIND_ALLOC) && (len_q == '0));

  assign s    = rdata.start;
  assign l    = rdata.len;
  assign e    = s + l;
  assign rend = off_q + len_q;
  assign nl   = l - len_q;

  assign room_rel = (cnt_q < CW'(MAX_EXTENTS));
  // live table size at this point of the claim scan
  assign live     = {1'b0, wptr_q} + ({1'b0, cnt_q} - {1'b0, idx_q});
  assign room_clm = (live < (CW+1)'(MAX_EXTENTS));

  always_comb begin
    ev_wr     = 1'b1;
    ev_w      = rdata;
    ev_two    = 1'b0;
    ev_x      = rdata;
    ev_done   = done_q;
    ev_pend   = pend_q;
    ev_car    = car_q;
    ev_st     = 1'b0;
    ev_at_set = 1'b0;
    case (kind_q)
      KIND_ALLOC: begin
        if (!done_q && (l >= len_q)) begin
          ev_at_set = 1'b1;
          ev_done   = 1'b1;
          ev_w      = '{start: s + len_q, len: nl};
          ev_wr     = (nl != '0);
        end
      end
      KIND_RELEASE: begin
        if (done_q) begin
          ev_wr = 1'b1;
        end else if (pend_q) begin
          ev_pend = 1'b0;
          ev_done = 1'b1;
          if (s == car_q.start + car_q.len) begin
            ev_w = '{start: car_q.start, len: car_q.len + l};
          end else begin
            ev_w   = car_q;
            ev_two = 1'b1;
          end
        end else if (e == off_q) begin
          ev_wr   = 1'b0;
          ev_pend = 1'b1;
          ev_car  = '{start: s, len: l + len_q};
        end else if (s == rend) begin
          ev_done = 1'b1;
          ev_w    = '{start: off_q, len: l + len_q};
        end else if (s > off_q) begin
          ev_done = 1'b1;
          if (room_rel) begin
            ev_w   = '{start: off_q, len: len_q};
            ev_two = 1'b1;
          end else begin
            ev_st = 1'b1;
          end
        end
      end
      KIND_CLAIM: begin
        if ((off_q <= s) && (e <= rend)) begin
          ev_wr = 1'b0;
        end else if ((off_q <= s) && (s < rend)) begin
          ev_w = '{start: rend, len: e - rend};
        end else if ((off_q < e) && (e <= rend)) begin
          ev_w = '{start: s, len: off_q - s};
        end else if ((s < off_q) && (rend < e)) begin
          if (room_clm) begin
            ev_w   = '{start: s, len: off_q - s};
            ev_x   = '{start: rend, len: e - rend};
            ev_two = 1'b1;
          end else begin
            ev_w  = '{start: rend, len: e - rend};
            ev_st = 1'b1;
          end
        end
      end
      default: ev_wr = 1'b0;
    endcase
  end

  always_comb begin
    tail_wr  = 1'b0;
    tail_st  = 1'b0;
    tail_w   = car_q;
    fin_at   = '0;
    fin_end  = end_q;
    fin_grew = 1'b0;
    case (kind_q)
      KIND_ALLOC: begin
        if (done_q) begin
          fin_at = at_q;
        end else begin
          fin_at   = end_q;
          fin_end  = end_q + len_q;
          fin_grew = (len_q != '0);
        end
      end
      KIND_RELEASE: begin
        if (!skip) begin
          if (pend_q) begin
            tail_wr = 1'b1;
          end else if (!done_q) begin
            tail_w  = '{start: off_q, len: len_q};
            tail_wr = room_rel;
            tail_st = !room_rel;
          end
        end
      end
      default: tail_wr = 1'b0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {~sel_q, wptr_q[AW-1:0]};
    ram_wdata = ev_w;
    if (cfg_we_i) begin
      ram_we    = 1'b1;
      ram_waddr = {sel_q, {AW{1'b0}}};
      ram_wdata = '{start: '0, len: cfg_wdata_i};
    end else if (cmd_i.eval) begin
      ram_we = ev_wr;
    end else if (cmd_i.extra) begin
      ram_we    = 1'b1;
      ram_wdata = xtr_q;
    end else if (cmd_i.finish) begin
      ram_we    = tail_wr;
      ram_wdata = tail_w;
    end
  end

  efla_ram #(
    .WIDTH($bits(ext_t)),
    .DEPTH(2 * (1 << AW))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i({sel_q, idx_q[AW-1:0]}),
    .rdata_o(rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      end_q       <= '0;
      sel_q       <= 1'b0;
      idx_q       <= '0;
      wptr_q      <= '0;
      done_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= CW'(cfg_wdata_i != '0);
        end_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q  <= '0;
        wptr_q <= '0;
        done_q <= 1'b0;
        pend_q <= 1'b0;
      end
      if (cmd_i.eval) begin
        idx_q  <= idx_q + CW'(1);
        wptr_q <= wptr_q + CW'(ev_wr);
        done_q <= ev_done;
        pend_q <= ev_pend;
      end
      if (cmd_i.extra) begin
        wptr_q <= wptr_q + CW'(1);
      end
      if (cmd_i.finish) begin
        end_q <= fin_end;
        if (!skip) begin
          sel_q <= ~sel_q;
          cnt_q <= wptr_q + CW'(tail_wr);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      off_q  <= offset_i;
      len_q  <= {{(POS_W-LEN_W){1'b0}}, length_i};
      at_q   <= '0;
      st_q   <= 1'b0;
      grew_q <= 1'b0;
    end
    if (cmd_i.eval) begin
      car_q <= ev_car;
      if (ev_two) begin
        xtr_q <= ev_x;
      end
      if (ev_at_set) begin
        at_q <= s;
      end
      if (ev_st) begin
        st_q <= 1'b1;
      end
    end
    if (cmd_i.finish) begin
      out_at_q   <= fin_at;
      out_grew_q <= fin_grew | grew_q;
      out_end_q  <= fin_end;
      out_st_q   <= st_q | tail_st;
    end
  end

  assign sts_o.skip      = skip;
  assign sts_o.scan_done = (idx_q == cnt_q);
  assign sts_o.two_out   = ev_two;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign alloc_offset_o = out_at_q;
  assign grew_o         = out_grew_q;
  assign store_end_o    = out_end_q;
  assign status_o       = out_st_q;

endmodule

// ===== hdl/efla_chk.sv =====
`include "extent_free_list_allocator_defines.svh"

module efla_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [39:0] alloc_offset_o,
  input logic        grew_o,
  input logic [39:0] store_end_o,
  input logic        status_o
);

  // one word in flight: the block stalls right after taking one
  `EFLA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "took a second word")

  // a growing allocate of nonzero length moves the store end off its start
  `EFLA_ASSERT_SAME(a_grew_moves_end, out_valid_o && grew_o, store_end_o != alloc_offset_o, "grew without moving end")

  // growth only on allocate, table overflow only on release or claim
  `EFLA_ASSERT_SAME(a_grew_no_status, out_valid_o && grew_o, !status_o, "grew and status both set")

  `EFLA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(store_end_o) && $stable(alloc_offset_o), "stalled result changed")

endmodule

bind extent_free_list_allocator efla_chk u_chk (.*);
